// ===== hdl/vcms_pkg.sv =====
// Package for the version-chained message store.
// Holds sizes, codes, item types and the control structs used by vcms_if, vcms_pending and the top level.
// No dependencies.
package vcms_pkg;

  localparam int KEY_SLOTS     = 8;
  localparam int QUEUE_DEPTH   = 32;   // power of two: queues wrap by masking
  localparam int PENDING_SLOTS = 4;
  localparam int PENDING_LIMIT = 3;

  localparam int SLOT_W  = $clog2(KEY_SLOTS);
  localparam int OFS_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int NUSE_W  = $clog2(KEY_SLOTS + 1);
  localparam int PIDX_W  = $clog2(PENDING_SLOTS);
  localparam int PCNT_W  = $clog2(PENDING_SLOTS + 1);
  localparam int ADDR_W  = SLOT_W + OFS_W;
  localparam int LEN_W   = 9;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LIMIT       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PENDING_TIMEOUT = 2'd2;
  localparam logic [3:0]  KEY_LIMIT_RST       = 4'd5;
  localparam logic [5:0]  QUEUE_LIMIT_RST     = 6'd20;
  localparam logic [15:0] PENDING_TIMEOUT_RST = 16'd600;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_ALIGN  = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAIL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [63:0] message_key;
    logic signed [63:0] current_version;
    logic signed [63:0] previous_version;
    logic signed [63:0] payload;
    logic [31:0]        now_seconds;
    logic signed [63:0] min_version;
    logic [2:0]         slot_index;
    logic [4:0]         entry_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [8:0]         total_length;
    logic [8:0]         removed_count;
    logic signed [63:0] newest_version;
    logic signed [63:0] read_key;
    logic signed [63:0] read_current;
    logic signed [63:0] read_previous;
    logic signed [63:0] read_payload;
    logic [5:0]         read_count;
  } out_item_t;

  // One queue entry as kept in the entry memory
  typedef struct packed {
    logic [63:0] cur;
    logic [63:0] prev;
    logic [63:0] pay;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One parked append
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] cur;
    logic [63:0] prev;
    logic [63:0] pay;
    logic [31:0] stamp;
  } pend_entry_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic              clr;
    logic [PIDX_W-1:0] pop_idx;
  } pend_ctl_t;

  typedef struct packed {
    logic [PCNT_W-1:0] count;
    logic              hit;
    logic [PIDX_W-1:0] hit_idx;
    logic              expired;
  } pend_sts_t;

endpackage

// ===== hdl/vcms_if.sv =====
// Valid/ready channel interfaces for the message store's input and result words.
// Depends on vcms_pkg for the word types.
interface vcms_in_if import vcms_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vcms_out_if import vcms_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/vcms_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module vcms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/vcms_pending.sv =====
// Pending store: parked appends in arrival order, chain search and timeout check.
// Depends on vcms_pkg.
module vcms_pending import vcms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pend_ctl_t   ctl_i,
  input  pend_entry_t push_ent_i,
  input  logic [63:0] newest_i,
  input  logic [31:0] now_i,
  input  logic [15:0] timeout_i,
  output pend_sts_t   sts_o,
  output pend_entry_t hit_ent_o
);

  pend_entry_t       ent_q [PENDING_SLOTS];
  logic [PCNT_W-1:0] cnt_q;
  logic              hit;
  logic [PIDX_W-1:0] hit_idx;
  logic              expired;

  // First parked entry that chains onto the newest version
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < PENDING_SLOTS; i++) begin
      if (!hit && (PCNT_W'(i) < cnt_q) && (ent_q[i].prev == newest_i)) begin
        hit     = 1'b1;
        hit_idx = PIDX_W'(i);
      end
    end
  end

  // A waiting time is the signed difference; a clock that went back never expires
  always_comb begin
    logic [32:0] waited;
    expired = 1'b0;
    for (int i = 0; i < PENDING_SLOTS; i++) begin
      waited = {1'b0, now_i} - {1'b0, ent_q[i].stamp};
      if ((PCNT_W'(i) < cnt_q) && !waited[32] && (waited[31:0] > {16'd0, timeout_i})) begin
        expired = 1'b1;
      end
    end
  end

  assign sts_o     = '{count: cnt_q, hit: hit, hit_idx: hit_idx, expired: expired};
  assign hit_ent_o = ent_q[hit_idx];

  // Fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl_i.clr) begin
      cnt_q <= '0;
    end else if (ctl_i.push) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (ctl_i.pop) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Entries: append at the tail, close the gap on a pop
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      ent_q[cnt_q[PIDX_W-1:0]] <= push_ent_i;
    end else if (ctl_i.pop) begin
      for (int i = 0; i < PENDING_SLOTS - 1; i++) begin
        if (PIDX_W'(i) >= ctl_i.pop_idx) begin
          ent_q[i] <= ent_q[i+1];
        end
      end
    end
  end

endmodule

// ===== hdl/version_chained_message_store.sv =====
// Version-chained message store: per-key queues in an entry RAM, with a pending store.
// Depends on vcms_pkg, vcms_if, vcms_ram and vcms_pending.
//
// Usage:
//   in_i carries one request word per handshake (append, alignment check, remove
//   older than a version, or read one entry); out_o returns exactly one result
//   word per request, in order. Configuration (key limit, queue limit, pending
//   timeout) is written through cfg_we_i/cfg_idx_i/cfg_data_i while the block is
//   idle; each write lands at the clock edge.
// Requests are handled one at a time: a new request word is accepted only in
// the idle state, so the block never takes a new request before the last is done.
//   A parked append replays each pending entry that then chains on; an alignment
//   check replays only when entries are pending; a remove examines the leading
//   entries of every used key slot in order, against the given version.
// A new request is accepted while the previous result still waits in the
// output register; when the receiver stalls, the block finishes that request
// and then holds in its final state until the output register frees.
// Reset empties all slots, queues and pending entries and loads the default
// limits; no memory clearing pass is needed, since counts guard every read.
module version_chained_message_store import vcms_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  vcms_in_if.sink               in_i,
  vcms_out_if.source            out_o
);

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_APPEND   = 16'h0002,
    S_REPLAY   = 16'h0004,
    S_CHECK    = 16'h0008,
    S_CHAIN    = 16'h0010,
    S_PLACE    = 16'h0020,
    S_EVICT    = 16'h0040,
    S_WRITE    = 16'h0080,
    S_RM_SLOT  = 16'h0100,
    S_RM_SCAN  = 16'h0200,
    S_RM_CMP   = 16'h0400,
    S_RM_APPLY = 16'h0800,
    S_RD       = 16'h1000,
    S_RD_DATA  = 16'h2000,
    S_FAIL     = 16'h4000,
    S_DONE     = 16'h8000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [3:0]  key_limit_q;
  logic [5:0]  queue_limit_q;
  logic [15:0] pend_timeout_q;

  // Slot table: logical order of keys, each mapped onto a physical queue region
  logic [63:0]       key_q   [KEY_SLOTS];
  logic [63:0]       key_d   [KEY_SLOTS];
  logic [SLOT_W-1:0] phys_q  [KEY_SLOTS];
  logic [SLOT_W-1:0] phys_d  [KEY_SLOTS];
  logic [OFS_W-1:0]  head_q  [KEY_SLOTS];
  logic [OFS_W-1:0]  head_d  [KEY_SLOTS];
  logic [CNT_W-1:0]  cnt_q   [KEY_SLOTS];
  logic [CNT_W-1:0]  cnt_d   [KEY_SLOTS];
  logic [NUSE_W-1:0] n_used_q, n_used_d;

  // Chain state
  logic [63:0] newest_q, newest_d;
  logic [63:0] oldest_q, oldest_d;
  logic [LEN_W-1:0] len_q, len_d;

  // Current request and working registers
  in_item_t          item_q, item_d;
  logic [63:0]       ch_key_q, ch_key_d;
  entry_t            ch_ent_q, ch_ent_d;
  logic              ch_pend_q, ch_pend_d;
  logic [PIDX_W-1:0] ch_pidx_q, ch_pidx_d;
  logic [SLOT_W-1:0] ch_s_q, ch_s_d;
  logic              ev_flag_q, ev_flag_d;
  logic [63:0]       ev_cur_q, ev_cur_d;
  logic [63:0]       ev_prev_q, ev_prev_d;
  logic [NUSE_W-1:0] rm_s_q, rm_s_d;
  logic [CNT_W-1:0]  rm_drop_q, rm_drop_d;

  // Result fields being built
  logic [1:0]       res_status_q, res_status_d;
  logic [LEN_W-1:0] res_removed_q, res_removed_d;
  logic [63:0]      res_key_q, res_key_d;
  entry_t           res_ent_q, res_ent_d;
  logic [CNT_W-1:0] res_count_q, res_count_d;

  // Output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  // Entry RAM
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  entry_t             rd_ent;

  // Pending store
  pend_ctl_t   pend_ctl;
  pend_sts_t   pend_sts;
  pend_entry_t pend_push_ent, pend_hit_ent;

  // Derived limits and lookups
  logic [NUSE_W-1:0] klim;
  logic [CNT_W-1:0]  qlim;
  logic              fresh;
  logic              key_hit;
  logic [SLOT_W-1:0] key_pos;
  logic              in_fire;
  logic [SLOT_W-1:0] s_cur;
  logic [SLOT_W-1:0] rm_sel;
  logic [SLOT_W-1:0] rd_sel;

  vcms_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (KEY_SLOTS * QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_ent = entry_t'(ram_rdata);

  vcms_pending u_pending (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (pend_ctl),
    .push_ent_i (pend_push_ent),
    .newest_i   (newest_q),
    .now_i      (item_q.now_seconds),
    .timeout_i  (pend_timeout_q),
    .sts_o      (pend_sts),
    .hit_ent_o  (pend_hit_ent)
  );

  assign pend_push_ent = '{key:   item_q.message_key,
                           cur:   item_q.current_version,
                           prev:  item_q.previous_version,
                           pay:   item_q.payload,
                           stamp: item_q.now_seconds};

  // Handshake ports
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Effective limits: key limit saturates, queue limit of zero acts as one
  assign klim = (key_limit_q > 4'(KEY_SLOTS)) ? NUSE_W'(KEY_SLOTS) : NUSE_W'(key_limit_q);
  always_comb begin
    if (queue_limit_q == '0) begin
      qlim = CNT_W'(1);
    end else if (queue_limit_q > 6'(QUEUE_DEPTH)) begin
      qlim = CNT_W'(QUEUE_DEPTH);
    end else begin
      qlim = CNT_W'(queue_limit_q);
    end
  end

  assign fresh  = (newest_q == '0) && (oldest_q == '0);
  assign s_cur  = ch_s_q;
  assign rm_sel = rm_s_q[SLOT_W-1:0];
  assign rd_sel = item_q.slot_index;

  // Key search over the used slots, first match wins
  always_comb begin
    key_hit = 1'b0;
    key_pos = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (!key_hit && (NUSE_W'(i) < n_used_q) && (key_q[i] == ch_key_q)) begin
        key_hit = 1'b1;
        key_pos = SLOT_W'(i);
      end
    end
  end

  // Sequencer
  always_comb begin
    logic [CNT_W-1:0] left;
    logic [63:0]      old1;

    state_d       = state_q;
    key_d         = key_q;
    phys_d        = phys_q;
    head_d        = head_q;
    cnt_d         = cnt_q;
    n_used_d      = n_used_q;
    newest_d      = newest_q;
    oldest_d      = oldest_q;
    len_d         = len_q;
    item_d        = item_q;
    ch_key_d      = ch_key_q;
    ch_ent_d      = ch_ent_q;
    ch_pend_d     = ch_pend_q;
    ch_pidx_d     = ch_pidx_q;
    ch_s_d        = ch_s_q;
    ev_flag_d     = ev_flag_q;
    ev_cur_d      = ev_cur_q;
    ev_prev_d     = ev_prev_q;
    rm_s_d        = rm_s_q;
    rm_drop_d     = rm_drop_q;
    res_status_d  = res_status_q;
    res_removed_d = res_removed_q;
    res_key_d     = res_key_q;
    res_ent_d     = res_ent_q;
    res_count_d   = res_count_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_d         = out_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = '0;
    ram_raddr     = '0;
    ram_wdata     = '0;
    pend_ctl      = '0;
    left          = '0;
    old1          = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          item_d        = in_i.data;
          res_status_d  = ST_OK;
          res_removed_d = '0;
          res_key_d     = '0;
          res_ent_d     = '0;
          res_count_d   = '0;
          case (action_e'(in_i.data.action))
            ACT_APPEND: begin
              len_d   = len_q + 1'b1;
              state_d = S_APPEND;
            end
            ACT_ALIGN: begin
              state_d = (pend_sts.count != '0) ? S_REPLAY : S_DONE;
            end
            ACT_REMOVE: begin
              rm_s_d  = '0;
              state_d = S_RM_SLOT;
            end
            default: begin
              state_d = S_RD;
            end
          endcase
        end
      end

      // Direct chaining, or park the append, or fail when the pending store is full
      S_APPEND: begin
        if (fresh || (newest_q == item_q.previous_version)) begin
          ch_key_d  = item_q.message_key;
          ch_ent_d  = '{cur: item_q.current_version, prev: item_q.previous_version,
                        pay: item_q.payload};
          ch_pend_d = 1'b0;
          state_d   = S_CHAIN;
        end else if (pend_sts.count == PCNT_W'(PENDING_SLOTS)) begin
          state_d = S_FAIL;
        end else begin
          pend_ctl.push = 1'b1;
          state_d       = S_REPLAY;
        end
      end

      // Replay the first parked entry that chains on
      S_REPLAY: begin
        if (pend_sts.hit) begin
          ch_key_d  = pend_hit_ent.key;
          ch_ent_d  = '{cur: pend_hit_ent.cur, prev: pend_hit_ent.prev, pay: pend_hit_ent.pay};
          ch_pend_d = 1'b1;
          ch_pidx_d = pend_sts.hit_idx;
          state_d   = S_CHAIN;
        end else begin
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        if (pend_sts.expired || (pend_sts.count > PCNT_W'(PENDING_LIMIT))) begin
          state_d = S_FAIL;
        end else begin
          state_d = S_DONE;
        end
      end

      // Find the key's slot or open a new one at the end, or fail at the key limit
      S_CHAIN: begin
        if (key_hit) begin
          ch_s_d  = key_pos;
          state_d = S_PLACE;
        end else if (n_used_q >= klim) begin
          state_d = S_FAIL;
        end else begin
          ch_s_d                         = n_used_q[SLOT_W-1:0];
          key_d[n_used_q[SLOT_W-1:0]]  = ch_key_q;
          cnt_d[n_used_q[SLOT_W-1:0]]  = '0;
          head_d[n_used_q[SLOT_W-1:0]] = '0;
          n_used_d                       = n_used_q + 1'b1;
          state_d                        = S_PLACE;
        end
      end

      // A full queue first reads its oldest entry for eviction
      S_PLACE: begin
        if (cnt_q[s_cur] >= qlim) begin
          ram_re    = 1'b1;
          ram_raddr = {phys_q[s_cur], head_q[s_cur]};
          state_d   = S_EVICT;
        end else begin
          ev_flag_d = 1'b0;
          state_d   = S_WRITE;
        end
      end

      S_EVICT: begin
        ev_cur_d      = rd_ent.cur;
        ev_prev_d     = rd_ent.prev;
        head_d[s_cur] = head_q[s_cur] + 1'b1;
        cnt_d[s_cur]  = cnt_q[s_cur] - 1'b1;
        ev_flag_d     = 1'b1;
        state_d       = S_WRITE;
      end

      // Append at the queue tail and move the chain ends
      S_WRITE: begin
        ram_we       = 1'b1;
        ram_waddr    = {phys_q[s_cur], OFS_W'(head_q[s_cur] + cnt_q[s_cur][OFS_W-1:0])};
        ram_wdata    = ch_ent_q;
        cnt_d[s_cur] = cnt_q[s_cur] + 1'b1;
        old1         = fresh ? ch_ent_q.prev : oldest_q;
        newest_d     = ch_ent_q.cur;
        oldest_d     = old1;
        if (ev_flag_q) begin
          len_d = len_q - 1'b1;
          if (old1 == ev_prev_q) begin
            oldest_d = ev_cur_q;
          end
        end
        if (ch_pend_q) begin
          pend_ctl.pop     = 1'b1;
          pend_ctl.pop_idx = ch_pidx_q;
          state_d          = S_REPLAY;
        end else begin
          state_d = S_DONE;
        end
      end

      // Remove: walk the used slots in order
      S_RM_SLOT: begin
        if (rm_s_q >= n_used_q) begin
          len_d   = len_q - res_removed_q;
          state_d = S_DONE;
        end else begin
          rm_drop_d = '0;
          state_d   = S_RM_SCAN;
        end
      end

      S_RM_SCAN: begin
        if (rm_drop_q < cnt_q[rm_sel]) begin
          ram_re    = 1'b1;
          ram_raddr = {phys_q[rm_sel], OFS_W'(head_q[rm_sel] + rm_drop_q[OFS_W-1:0])};
          state_d   = S_RM_CMP;
        end else begin
          state_d = S_RM_APPLY;
        end
      end

      S_RM_CMP: begin
        if ($signed(rd_ent.cur) < $signed(item_q.min_version)) begin
          rm_drop_d = rm_drop_q + 1'b1;
          state_d   = S_RM_SCAN;
        end else begin
          state_d = S_RM_APPLY;
        end
      end

      // Drop the leading entries; an emptied slot leaves and later slots move up
      S_RM_APPLY: begin
        left           = cnt_q[rm_sel] - rm_drop_q;
        res_removed_d  = res_removed_q + LEN_W'(rm_drop_q);
        head_d[rm_sel] = OFS_W'(head_q[rm_sel] + rm_drop_q[OFS_W-1:0]);
        cnt_d[rm_sel]  = left;
        if (left == '0) begin
          for (int k = 0; k < KEY_SLOTS - 1; k++) begin
            if ((SLOT_W'(k) >= rm_sel) && (NUSE_W'(k + 1) < n_used_q)) begin
              key_d[k]  = key_q[k+1];
              phys_d[k] = phys_q[k+1];
              head_d[k] = head_q[k+1];
              cnt_d[k]  = cnt_q[k+1];
            end
          end
          phys_d[SLOT_W'(n_used_q - 1'b1)] = phys_q[rm_sel];
          cnt_d[SLOT_W'(n_used_q - 1'b1)]  = '0;
          n_used_d                         = n_used_q - 1'b1;
        end else begin
          rm_s_d = rm_s_q + 1'b1;
        end
        state_d = S_RM_SLOT;
      end

      // Read one entry
      S_RD: begin
        res_status_d = ST_EMPTY;
        state_d      = S_DONE;
        if ({1'b0, rd_sel} < n_used_q) begin
          res_key_d   = key_q[rd_sel];
          res_count_d = cnt_q[rd_sel];
          if ({1'b0, item_q.entry_index} < cnt_q[rd_sel]) begin
            ram_re    = 1'b1;
            ram_raddr = {phys_q[rd_sel], OFS_W'(head_q[rd_sel] + item_q.entry_index)};
            state_d   = S_RD_DATA;
          end
        end
      end

      S_RD_DATA: begin
        res_ent_d    = rd_ent;
        res_status_d = ST_OK;
        state_d      = S_DONE;
      end

      // Failure clears the whole store
      S_FAIL: begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
          cnt_d[i] = '0;
        end
        n_used_d     = '0;
        pend_ctl.clr = 1'b1;
        newest_d     = '0;
        oldest_d     = '0;
        len_d        = '0;
        res_status_d = ST_FAIL;
        state_d      = S_DONE;
      end

      // Hand the result word to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d         = 1'b1;
          out_d.status        = res_status_q;
          out_d.total_length  = len_q;
          out_d.removed_count = res_removed_q;
          out_d.newest_version = newest_q;
          out_d.read_key      = res_key_q;
          out_d.read_current  = res_ent_q.cur;
          out_d.read_previous = res_ent_q.prev;
          out_d.read_payload  = res_ent_q.pay;
          out_d.read_count    = res_count_q;
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_limit_q    <= KEY_LIMIT_RST;
      queue_limit_q  <= QUEUE_LIMIT_RST;
      pend_timeout_q <= PENDING_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY_LIMIT:       key_limit_q    <= cfg_data_i[3:0];
        REG_QUEUE_LIMIT:     queue_limit_q  <= cfg_data_i[5:0];
        REG_PENDING_TIMEOUT: pend_timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_used_q    <= '0;
      newest_q    <= '0;
      oldest_q    <= '0;
      len_q       <= '0;
      ch_pend_q   <= 1'b0;
      ch_pidx_q   <= '0;
      ch_s_q      <= '0;
      ev_flag_q   <= 1'b0;
      rm_s_q      <= '0;
      rm_drop_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        phys_q[i] <= SLOT_W'(i);
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      n_used_q    <= n_used_d;
      newest_q    <= newest_d;
      oldest_q    <= oldest_d;
      len_q       <= len_d;
      ch_pend_q   <= ch_pend_d;
      ch_pidx_q   <= ch_pidx_d;
      ch_s_q      <= ch_s_d;
      ev_flag_q   <= ev_flag_d;
      rm_s_q      <= rm_s_d;
      rm_drop_q   <= rm_drop_d;
      out_valid_q <= out_valid_d;
      phys_q      <= phys_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q         <= key_d;
    item_q        <= item_d;
    ch_key_q      <= ch_key_d;
    ch_ent_q      <= ch_ent_d;
    ev_cur_q      <= ev_cur_d;
    ev_prev_q     <= ev_prev_d;
    res_status_q  <= res_status_d;
    res_removed_q <= res_removed_d;
    res_key_q     <= res_key_d;
    res_ent_q     <= res_ent_d;
    res_count_q   <= res_count_d;
    out_q         <= out_d;
  end

  // The sequencer never reads and writes the entry RAM in the same cycle.
  a_ram_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("entry RAM read and write in the same cycle");

  // A failure leaves an empty store behind.
  a_fail_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FAIL) |=> (len_q == '0 && n_used_q == '0 && newest_q == '0))
    else $error("store not cleared after failure");

  // Never more used slots than the table holds.
  a_slots_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_used_q <= NUSE_W'(KEY_SLOTS))
    else $error("used slot count out of range");

  // Between requests the first used slot holds at least one entry.
  a_used_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && n_used_q != '0) |-> (cnt_q[0] != '0))
    else $error("empty queue left in a used slot");

endmodule
